FILE: src/collision_shape_table_query_defines.svh
// assertion macros shared by the query block
`ifndef COLLISION_SHAPE_TABLE_QUERY_DEFINES_SVH
`define COLLISION_SHAPE_TABLE_QUERY_DEFINES_SVH

// plain invariant, sampled on the block clock
`define CSQ_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// same-cycle implication
`define CSQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: src/csq_pkg.sv
package csq_pkg;

  localparam int unsigned TableDepthDef = 16;
  localparam int unsigned CoordBits     = 16;
  localparam int unsigned SizeBits      = 15;
  localparam int unsigned OwnerBits     = 16;
  localparam int unsigned SlotBits      = 4;
  localparam int unsigned MaxOut        = 16;
  localparam int unsigned ColLatency    = 3;

  // commands
  localparam logic [2:0] CMD_ADD    = 3'd0;
  localparam logic [2:0] CMD_MOVE   = 3'd1;
  localparam logic [2:0] CMD_REMOVE = 3'd2;
  localparam logic [2:0] CMD_OWNER  = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;
  localparam logic [2:0] CMD_QUERY  = 3'd5;

  // shape kinds
  localparam logic [1:0] KIND_RECT  = 2'd0;
  localparam logic [1:0] KIND_CIRC  = 2'd1;
  localparam logic [1:0] KIND_POINT = 2'd2;

  // result status
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_NONE  = 2'd3;

  typedef struct packed {
    logic [1:0]                  kind;
    logic signed [CoordBits-1:0] x;
    logic signed [CoordBits-1:0] y;
    logic [SizeBits-1:0]         w;
    logic [SizeBits-1:0]         h;
    logic [SizeBits-1:0]         r;
    logic [OwnerBits-1:0]        owner;
  } entry_t;

  typedef struct packed {
    logic done;
    logic hit;
  } col_res_t;

endpackage

FILE: src/csq_if.sv
interface csq_cmd_if;
  logic                                   valid;
  logic                                   ready;
  logic [2:0]                             cmd;
  logic [csq_pkg::SlotBits-1:0]           slot;
  logic [1:0]                             kind;
  logic signed [csq_pkg::CoordBits-1:0]   pos_x;
  logic signed [csq_pkg::CoordBits-1:0]   pos_y;
  logic [csq_pkg::SizeBits-1:0]           size_w;
  logic [csq_pkg::SizeBits-1:0]           size_h;
  logic [csq_pkg::SizeBits-1:0]           rad;
  logic [csq_pkg::OwnerBits-1:0]          owner_tag;

  modport source (output valid, cmd, slot, kind, pos_x, pos_y, size_w, size_h, rad,
                  owner_tag, input ready);
  modport sink   (input valid, cmd, slot, kind, pos_x, pos_y, size_w, size_h, rad,
                  owner_tag, output ready);
endinterface

interface csq_res_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [csq_pkg::SlotBits-1:0]  hit_slot;
  logic [csq_pkg::OwnerBits-1:0] hit_owner;
  logic                          last;

  modport source (output valid, status, hit_slot, hit_owner, last, input ready);
  modport sink   (input valid, status, hit_slot, hit_owner, last, output ready);
endinterface

FILE: src/collision_shape_table_query.sv
// add scans the valid bits for the lowest free slot; move reads the entry and writes it
// back with the new center; remove by owner reads only occupied slots
// query: skips its own slot and empty slots and runs the pair test on each occupied one;
// the registered read of the entry memory and the 3-stage test set how long it runs
// throughput: one command at a time, the next is taken when the last result is queued
// reset: clears the valid bits and the control state at once, no clearing pass
`include "collision_shape_table_query_defines.svh"

module collision_shape_table_query #(
  parameter int unsigned TableDepth = csq_pkg::TableDepthDef
) (
  input logic       clk_i,
  input logic       rst_ni,
  csq_cmd_if.sink   cmd_i,
  csq_res_if.source res_o
);
  import csq_pkg::*;

  localparam int unsigned AW = $clog2(TableDepth);
  localparam int unsigned IW = $clog2(TableDepth + 1);
  localparam int unsigned CW = $clog2(MaxOut);

  // controller states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISP     = 4'd1;
  localparam logic [3:0] S_REPLY    = 4'd2;
  localparam logic [3:0] S_ADD      = 4'd3;
  localparam logic [3:0] S_MV_WAIT  = 4'd4;
  localparam logic [3:0] S_OWN      = 4'd5;
  localparam logic [3:0] S_OWN_WAIT = 4'd6;
  localparam logic [3:0] S_Q_WAIT   = 4'd7;
  localparam logic [3:0] S_WALK     = 4'd8;
  localparam logic [3:0] S_WAIT     = 4'd9;
  localparam logic [3:0] S_CALC     = 4'd10;
  localparam logic [3:0] S_HIT      = 4'd11;
  localparam logic [3:0] S_FIN      = 4'd12;

  logic [3:0]            state_q, state_d;
  logic [IW-1:0]         idx_q, idx_d;
  logic [TableDepth-1:0] valid_q, valid_d;

  // latched command word
  logic [2:0]                  c_cmd_q;
  logic [SlotBits-1:0]         c_slot_q;
  logic [1:0]                  c_kind_q;
  logic signed [CoordBits-1:0] c_x_q, c_y_q;
  logic [SizeBits-1:0]         c_w_q, c_h_q, c_r_q;
  logic [OwnerBits-1:0]        c_tag_q;

  // single reply and query bookkeeping
  logic [1:0]           rep_st_q, rep_st_d;
  logic [SlotBits-1:0]  rep_slot_q, rep_slot_d;
  entry_t               qent_q, qent_d;
  logic                 pend_v_q, pend_v_d;
  logic [SlotBits-1:0]  pend_slot_q, pend_slot_d;
  logic [OwnerBits-1:0] pend_owner_q, pend_owner_d;
  logic [OwnerBits-1:0] cand_owner_q, cand_owner_d;
  logic [CW-1:0]        emit_cnt_q, emit_cnt_d;

  // output register toward the result channel
  logic                 out_v_q, out_v_d;
  logic [1:0]           out_st_q, out_st_d;
  logic [SlotBits-1:0]  out_slot_q, out_slot_d;
  logic [OwnerBits-1:0] out_owner_q, out_owner_d;
  logic                 out_last_q, out_last_d;

  // memory and test unit hookup
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata, mem_rdata, new_ent;
  logic          col_start;
  col_res_t      col_res;

  logic          cmd_acc, out_free, slot_ok, at_end, idx_is_slot;
  logic [AW-1:0] idx_a, slot_a;
  logic          in_walk, res_miss;

  assign cmd_acc     = cmd_i.valid && cmd_i.ready;
  assign cmd_i.ready = (state_q == S_IDLE);
  assign out_free    = !out_v_q || res_o.ready;
  assign idx_a       = idx_q[AW-1:0];
  assign slot_a      = AW'(c_slot_q);
  assign slot_ok     = (32'(c_slot_q) < TableDepth) && valid_q[slot_a];
  assign at_end      = (idx_q == IW'(TableDepth));
  assign idx_is_slot = (32'(idx_q) == 32'(c_slot_q));

  // shape as stored on add: sizes that do not belong to the kind are zero
  always_comb begin
    new_ent.kind  = c_kind_q;
    new_ent.x     = c_x_q;
    new_ent.y     = c_y_q;
    new_ent.w     = (c_kind_q == KIND_RECT) ? c_w_q : '0;
    new_ent.h     = (c_kind_q == KIND_RECT) ? c_h_q : '0;
    new_ent.r     = (c_kind_q == KIND_CIRC) ? c_r_q : '0;
    new_ent.owner = c_tag_q;
  end

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    valid_d      = valid_q;
    rep_st_d     = rep_st_q;
    rep_slot_d   = rep_slot_q;
    qent_d       = qent_q;
    pend_v_d     = pend_v_q;
    pend_slot_d  = pend_slot_q;
    pend_owner_d = pend_owner_q;
    cand_owner_d = cand_owner_q;
    emit_cnt_d   = emit_cnt_q;
    out_v_d      = out_v_q && !res_o.ready;
    out_st_d     = out_st_q;
    out_slot_d   = out_slot_q;
    out_owner_d  = out_owner_q;
    out_last_d   = out_last_q;
    mem_we       = 1'b0;
    mem_waddr    = idx_a;
    mem_wdata    = new_ent;
    mem_re       = 1'b0;
    mem_raddr    = idx_a;
    col_start    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (cmd_acc) begin
          state_d = S_DISP;
        end
      end

      S_DISP: begin
        case (c_cmd_q)
          CMD_ADD: begin
            idx_d   = '0;
            state_d = S_ADD;
          end
          CMD_MOVE: begin
            if (!slot_ok) begin
              rep_st_d   = ST_EMPTY;
              rep_slot_d = c_slot_q;
              state_d    = S_REPLY;
            end else begin
              // read the entry, merge the new center, write it back
              mem_re    = 1'b1;
              mem_raddr = slot_a;
              state_d   = S_MV_WAIT;
            end
          end
          CMD_REMOVE: begin
            rep_slot_d = c_slot_q;
            state_d    = S_REPLY;
            if (!slot_ok) begin
              rep_st_d = ST_EMPTY;
            end else begin
              rep_st_d        = ST_OK;
              valid_d[slot_a] = 1'b0;
            end
          end
          CMD_OWNER: begin
            idx_d   = '0;
            state_d = S_OWN;
          end
          CMD_CLEAR: begin
            valid_d    = '0;
            rep_st_d   = ST_OK;
            rep_slot_d = '0;
            state_d    = S_REPLY;
          end
          CMD_QUERY: begin
            if (!slot_ok) begin
              rep_st_d   = ST_EMPTY;
              rep_slot_d = c_slot_q;
              state_d    = S_REPLY;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = slot_a;
              state_d   = S_Q_WAIT;
            end
          end
          default: begin
            // undefined commands give no word
            state_d = S_IDLE;
          end
        endcase
      end

      S_REPLY: begin
        if (out_free) begin
          out_v_d     = 1'b1;
          out_st_d    = rep_st_q;
          out_slot_d  = rep_slot_q;
          out_owner_d = '0;
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end

      // lowest free slot, one valid bit per cycle
      S_ADD: begin
        if (at_end) begin
          rep_st_d   = ST_FULL;
          rep_slot_d = '0;
          state_d    = S_REPLY;
        end else if (!valid_q[idx_a]) begin
          mem_we         = 1'b1;
          valid_d[idx_a] = 1'b1;
          rep_st_d       = ST_OK;
          rep_slot_d     = SlotBits'(idx_q);
          state_d        = S_REPLY;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end

      S_MV_WAIT: begin
        mem_we      = 1'b1;
        mem_waddr   = slot_a;
        mem_wdata   = mem_rdata;
        mem_wdata.x = c_x_q;
        mem_wdata.y = c_y_q;
        rep_st_d    = ST_OK;
        rep_slot_d  = c_slot_q;
        state_d     = S_REPLY;
      end

      // owner sweep reads only occupied entries
      S_OWN: begin
        if (at_end) begin
          rep_st_d   = ST_OK;
          rep_slot_d = '0;
          state_d    = S_REPLY;
        end else if (valid_q[idx_a]) begin
          mem_re  = 1'b1;
          state_d = S_OWN_WAIT;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end

      S_OWN_WAIT: begin
        if (mem_rdata.owner == c_tag_q) begin
          valid_d[idx_a] = 1'b0;
        end
        idx_d   = idx_q + IW'(1);
        state_d = S_OWN;
      end

      S_Q_WAIT: begin
        qent_d     = mem_rdata;
        idx_d      = '0;
        pend_v_d   = 1'b0;
        emit_cnt_d = '0;
        state_d    = S_WALK;
      end

      // query walk over the table in slot order
      S_WALK: begin
        if (at_end) begin
          state_d = S_FIN;
        end else if (idx_is_slot || !valid_q[idx_a]) begin
          idx_d = idx_q + IW'(1);
        end else begin
          mem_re  = 1'b1;
          state_d = S_WAIT;
        end
      end

      S_WAIT: begin
        col_start    = 1'b1;
        cand_owner_d = mem_rdata.owner;
        state_d      = S_CALC;
      end

      S_CALC: begin
        if (col_res.done) begin
          if (col_res.hit) begin
            state_d = S_HIT;
          end else begin
            idx_d   = idx_q + IW'(1);
            state_d = S_WALK;
          end
        end
      end

      // a hit is held back one step so the final one can carry last
      S_HIT: begin
        if (!pend_v_q) begin
          pend_v_d     = 1'b1;
          pend_slot_d  = SlotBits'(idx_q);
          pend_owner_d = cand_owner_q;
          if (32'(emit_cnt_q) == MaxOut - 1) begin
            state_d = S_FIN;
          end else begin
            idx_d   = idx_q + IW'(1);
            state_d = S_WALK;
          end
        end else if (out_free) begin
          out_v_d      = 1'b1;
          out_st_d     = ST_OK;
          out_slot_d   = pend_slot_q;
          out_owner_d  = pend_owner_q;
          out_last_d   = 1'b0;
          emit_cnt_d   = emit_cnt_q + CW'(1);
          pend_slot_d  = SlotBits'(idx_q);
          pend_owner_d = cand_owner_q;
          // output cap reached: the held hit closes the query
          if (32'(emit_cnt_q) + 1 == MaxOut - 1) begin
            state_d = S_FIN;
          end else begin
            idx_d   = idx_q + IW'(1);
            state_d = S_WALK;
          end
        end
      end

      S_FIN: begin
        if (out_free) begin
          out_v_d    = 1'b1;
          out_last_d = 1'b1;
          if (pend_v_q) begin
            out_st_d    = ST_OK;
            out_slot_d  = pend_slot_q;
            out_owner_d = pend_owner_q;
          end else begin
            out_st_d    = ST_NONE;
            out_slot_d  = c_slot_q;
            out_owner_d = '0;
          end
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      valid_q    <= '0;
      out_v_q    <= 1'b0;
      pend_v_q   <= 1'b0;
      emit_cnt_q <= '0;
    end else begin
      state_q    <= state_d;
      valid_q    <= valid_d;
      out_v_q    <= out_v_d;
      pend_v_q   <= pend_v_d;
      emit_cnt_q <= emit_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    rep_st_q     <= rep_st_d;
    rep_slot_q   <= rep_slot_d;
    qent_q       <= qent_d;
    pend_slot_q  <= pend_slot_d;
    pend_owner_q <= pend_owner_d;
    cand_owner_q <= cand_owner_d;
    out_st_q     <= out_st_d;
    out_slot_q   <= out_slot_d;
    out_owner_q  <= out_owner_d;
    out_last_q   <= out_last_d;
  end

  // command word capture
  always_ff @(posedge clk_i) begin
    if (cmd_acc) begin
      c_cmd_q  <= cmd_i.cmd;
      c_slot_q <= cmd_i.slot;
      c_kind_q <= cmd_i.kind;
      c_x_q    <= cmd_i.pos_x;
      c_y_q    <= cmd_i.pos_y;
      c_w_q    <= cmd_i.size_w;
      c_h_q    <= cmd_i.size_h;
      c_r_q    <= cmd_i.rad;
      c_tag_q  <= cmd_i.owner_tag;
    end
  end

  assign res_o.valid     = out_v_q;
  assign res_o.status    = out_st_q;
  assign res_o.hit_slot  = out_slot_q;
  assign res_o.hit_owner = out_owner_q;
  assign res_o.last      = out_last_q;

  // entry store: one write and one registered read per cycle; the controller
  // never reads an entry in the cycle it writes it
  csq_mem #(
    .Depth (TableDepth)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // pair test: query entry against the word just read
  csq_collide u_collide (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (col_start),
    .a_i     (qent_q),
    .b_i     (mem_rdata),
    .res_o   (col_res)
  );

  // query walk states and result words that are not hits
  assign in_walk  = (state_q == S_WALK) || (state_q == S_WAIT) || (state_q == S_CALC) ||
                    (state_q == S_HIT);
  assign res_miss = res_o.valid && (res_o.status != ST_OK);

  `CSQ_ASSERT_IMPL(a_col_latency, $past(col_start, ColLatency), col_res.done, "pair test late")
  `CSQ_ASSERT_IMPL(a_no_write_in_walk, in_walk, !mem_we, "entry written during query walk")
  `CSQ_ASSERT_IMPL(a_owner_only_on_hit, res_miss, res_o.hit_owner == '0, "owner without a hit")
  `CSQ_ASSERT(a_emit_cap, 32'(emit_cnt_q) < MaxOut, "query output count past cap")

endmodule

FILE: src/csq_mem.sv
module csq_mem #(
  parameter int unsigned Depth = csq_pkg::TableDepthDef
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  csq_pkg::entry_t          wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output csq_pkg::entry_t          rdata_o
);
  import csq_pkg::*;

  entry_t mem_q [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/csq_collide.sv
module csq_collide (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  csq_pkg::entry_t   a_i,
  input  csq_pkg::entry_t   b_i,
  output csq_pkg::col_res_t res_o
);
  import csq_pkg::*;

  localparam int unsigned EW = CoordBits + 3;
  localparam int unsigned TW = SizeBits + 1;

  localparam logic [1:0] MD_NONE = 2'd0;
  localparam logic [1:0] MD_SQ   = 2'd1;
  localparam logic [1:0] MD_ZERO = 2'd2;
  localparam logic [1:0] MD_RR   = 2'd3;

  // stage 1: role select, clamp, deltas
  logic                 cc, cr, cp, pr, rr, swap;
  entry_t               s, o;
  logic signed [EW-1:0] sx2, sy2, ox2, oy2, ow, oh, lox, hix, loy, hiy, nx, ny;
  logic signed [EW-1:0] ax2, ay2, bx2, by2, aw, ah, bw, bh;
  logic signed [EW-1:0] dx_d, dy_d;
  logic [TW-1:0]        t_d;
  logic [1:0]           mode_d;
  logic                 rr_d;

  always_comb begin
    cc = (a_i.kind == KIND_CIRC) && (b_i.kind == KIND_CIRC);
    rr = (a_i.kind == KIND_RECT) && (b_i.kind == KIND_RECT);
    cr = ((a_i.kind == KIND_CIRC) && (b_i.kind == KIND_RECT)) ||
         ((a_i.kind == KIND_RECT) && (b_i.kind == KIND_CIRC));
    cp = ((a_i.kind == KIND_CIRC) && (b_i.kind == KIND_POINT)) ||
         ((a_i.kind == KIND_POINT) && (b_i.kind == KIND_CIRC));
    pr = ((a_i.kind == KIND_POINT) && (b_i.kind == KIND_RECT)) ||
         ((a_i.kind == KIND_RECT) && (b_i.kind == KIND_POINT));
    // s is the round shape (circle or point), o the other one
    swap = !((a_i.kind == KIND_CIRC) ||
             ((a_i.kind == KIND_POINT) && (b_i.kind == KIND_RECT)));
    s = swap ? b_i : a_i;
    o = swap ? a_i : b_i;

    sx2 = EW'(signed'(s.x)) + EW'(signed'(s.x));
    sy2 = EW'(signed'(s.y)) + EW'(signed'(s.y));
    ox2 = EW'(signed'(o.x)) + EW'(signed'(o.x));
    oy2 = EW'(signed'(o.y)) + EW'(signed'(o.y));
    ow  = EW'(o.w);
    oh  = EW'(o.h);
    lox = ox2 - ow;
    hix = ox2 + ow;
    loy = oy2 - oh;
    hiy = oy2 + oh;
    nx  = (sx2 > hix) ? hix : ((sx2 < lox) ? lox : sx2);
    ny  = (sy2 > hiy) ? hiy : ((sy2 < loy) ? loy : sy2);

    // rectangle against rectangle, inclusive edges
    ax2 = EW'(signed'(a_i.x)) + EW'(signed'(a_i.x));
    ay2 = EW'(signed'(a_i.y)) + EW'(signed'(a_i.y));
    bx2 = EW'(signed'(b_i.x)) + EW'(signed'(b_i.x));
    by2 = EW'(signed'(b_i.y)) + EW'(signed'(b_i.y));
    aw  = EW'(a_i.w);
    ah  = EW'(a_i.h);
    bw  = EW'(b_i.w);
    bh  = EW'(b_i.h);
    rr_d = ((ax2 + aw) >= (bx2 - bw)) && ((ax2 - aw) <= (bx2 + bw)) &&
           ((ay2 + ah) >= (by2 - bh)) && ((ay2 - ah) <= (by2 + bh));

    if (cr || pr) begin
      dx_d = sx2 - nx;
      dy_d = sy2 - ny;
    end else begin
      dx_d = EW'(signed'(s.x)) - EW'(signed'(o.x));
      dy_d = EW'(signed'(s.y)) - EW'(signed'(o.y));
    end
    t_d = cr ? {s.r, 1'b0} : (TW'(s.r) + TW'(o.r));

    if (cc || cp || cr) begin
      mode_d = MD_SQ;
    end else if (pr) begin
      mode_d = MD_ZERO;
    end else if (rr) begin
      mode_d = MD_RR;
    end else begin
      mode_d = MD_NONE;
    end
  end

  logic                 v1_q, v2_q;
  logic signed [EW-1:0] dx1_q, dy1_q;
  logic [TW-1:0]        t1_q;
  logic [1:0]           mode1_q, mode2_q;
  logic                 rr1_q, rr2_q, zero2_q;
  logic [2*EW-1:0]      sqx2_q, sqy2_q;
  logic [2*TW-1:0]      tt2_q;
  logic [EW-1:0]        adx, ady;
  logic [2*EW:0]        dsum;
  logic                 hit_d;
  col_res_t             res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      res_q <= '0;
    end else begin
      v1_q       <= start_i;
      v2_q       <= v1_q;
      res_q.done <= v2_q;
      res_q.hit  <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dx1_q   <= dx_d;
    dy1_q   <= dy_d;
    t1_q    <= t_d;
    mode1_q <= mode_d;
    rr1_q   <= rr_d;
    sqx2_q  <= adx * adx;
    sqy2_q  <= ady * ady;
    tt2_q   <= t1_q * t1_q;
    zero2_q <= (dx1_q == '0) && (dy1_q == '0);
    mode2_q <= mode1_q;
    rr2_q   <= rr1_q;
  end

  // stage 2: magnitudes into the squarers
  assign adx = dx1_q[EW-1] ? EW'(-dx1_q) : EW'(dx1_q);
  assign ady = dy1_q[EW-1] ? EW'(-dy1_q) : EW'(dy1_q);

  // stage 3: strict compare of squared distance; point-box and box-box pass their flags through
  always_comb begin
    dsum = {1'b0, sqx2_q} + {1'b0, sqy2_q};
    case (mode2_q)
      MD_SQ:   hit_d = dsum < (2*EW+1)'(tt2_q);
      MD_ZERO: hit_d = zero2_q;
      MD_RR:   hit_d = rr2_q;
      default: hit_d = 1'b0;
    endcase
  end

  assign res_o = res_q;

endmodule

FILE: tb/csq_scoreboard.sv
module csq_scoreboard (
  input  logic clk_i,
  input  logic rst_ni,
  csq_cmd_if   cmd_mon,
  csq_res_if   res_mon,
  output int   fail_cnt_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import csq_pkg::*;

  localparam int Depth = TableDepthDef;

  typedef struct {
    logic [1:0]           status;
    logic [SlotBits-1:0]  hit_slot;
    logic [OwnerBits-1:0] hit_owner;
    logic                 last;
  } result_t;

  // shadow copy of the shape table
  bit                   occ_q   [Depth];
  logic [1:0]           kind_q  [Depth];
  longint               cx_q    [Depth];
  longint               cy_q    [Depth];
  longint               w_q     [Depth];
  longint               h_q     [Depth];
  longint               r_q     [Depth];
  logic [OwnerBits-1:0] owner_q [Depth];

  result_t result_q[$];

  function automatic longint sqr(longint d);
    return d * d;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v;
  endfunction

  // p is a point, q a rectangle; doubled coordinates
  function automatic bit point_in_box(int p, int q);
    return 2 * cx_q[p] >= 2 * cx_q[q] - w_q[q] && 2 * cx_q[p] <= 2 * cx_q[q] + w_q[q] &&
           2 * cy_q[p] >= 2 * cy_q[q] - h_q[q] && 2 * cy_q[p] <= 2 * cy_q[q] + h_q[q];
  endfunction

  function automatic bit disc_box(int c, int q);
    longint nx, ny;
    nx = clip(2 * cx_q[c], 2 * cx_q[q] - w_q[q], 2 * cx_q[q] + w_q[q]);
    ny = clip(2 * cy_q[c], 2 * cy_q[q] - h_q[q], 2 * cy_q[q] + h_q[q]);
    return sqr(2 * cx_q[c] - nx) + sqr(2 * cy_q[c] - ny) < sqr(2 * r_q[c]);
  endfunction

  function automatic bit disc_point(int c, int p);
    return sqr(cx_q[p] - cx_q[c]) + sqr(cy_q[p] - cy_q[c]) < sqr(r_q[c]);
  endfunction

  function automatic bit shapes_touch(int a, int b);
    logic [1:0] ka, kb;
    ka = kind_q[a];
    kb = kind_q[b];
    if (ka == KIND_CIRC && kb == KIND_CIRC)
      return sqr(cx_q[a] - cx_q[b]) + sqr(cy_q[a] - cy_q[b]) < sqr(r_q[a] + r_q[b]);
    if (ka == KIND_RECT && kb == KIND_RECT)
      return !(2 * cx_q[a] + w_q[a] < 2 * cx_q[b] - w_q[b] ||
               2 * cx_q[a] - w_q[a] > 2 * cx_q[b] + w_q[b] ||
               2 * cy_q[a] + h_q[a] < 2 * cy_q[b] - h_q[b] ||
               2 * cy_q[a] - h_q[a] > 2 * cy_q[b] + h_q[b]);
    if (ka == KIND_CIRC && kb == KIND_RECT)  return disc_box(a, b);
    if (ka == KIND_RECT && kb == KIND_CIRC)  return disc_box(b, a);
    if (ka == KIND_POINT && kb == KIND_CIRC) return disc_point(b, a);
    if (ka == KIND_CIRC && kb == KIND_POINT) return disc_point(a, b);
    if (ka == KIND_POINT && kb == KIND_RECT) return point_in_box(a, b);
    if (ka == KIND_RECT && kb == KIND_POINT) return point_in_box(b, a);
    return 1'b0;
  endfunction

  function automatic result_t mk(logic [1:0] st, int sl, logic [OwnerBits-1:0] ow,
                                 logic lst);
    result_t r;
    r.status    = st;
    r.hit_slot  = sl[SlotBits-1:0];
    r.hit_owner = ow;
    r.last      = lst;
    return r;
  endfunction

  // append one expected word at the tail
  function automatic void expect_word(result_t r);
    result_q.insert(result_q.size(), r);
  endfunction

  task automatic predict_command();
    int      s, free, n;
    bit      slot_ok;
    result_t hit;
    s       = int'(cmd_mon.slot);
    slot_ok = occ_q[s];
    case (cmd_mon.cmd)
      CMD_ADD: begin
        free = -1;
        for (int i = Depth - 1; i >= 0; i--) if (!occ_q[i]) free = i;
        if (free < 0) begin
          expect_word(mk(ST_FULL, 0, '0, 1'b1));
        end else begin
          occ_q[free]   = 1'b1;
          kind_q[free]  = cmd_mon.kind;
          cx_q[free]    = longint'(cmd_mon.pos_x);
          cy_q[free]    = longint'(cmd_mon.pos_y);
          w_q[free]     = (cmd_mon.kind == KIND_RECT) ? longint'(cmd_mon.size_w) : 0;
          h_q[free]     = (cmd_mon.kind == KIND_RECT) ? longint'(cmd_mon.size_h) : 0;
          r_q[free]     = (cmd_mon.kind == KIND_CIRC) ? longint'(cmd_mon.rad) : 0;
          owner_q[free] = cmd_mon.owner_tag;
          expect_word(mk(ST_OK, free, '0, 1'b1));
        end
      end
      CMD_MOVE, CMD_REMOVE: begin
        if (!slot_ok) begin
          expect_word(mk(ST_EMPTY, s, '0, 1'b1));
        end else begin
          if (cmd_mon.cmd == CMD_MOVE) begin
            cx_q[s] = longint'(cmd_mon.pos_x);
            cy_q[s] = longint'(cmd_mon.pos_y);
          end else begin
            occ_q[s] = 1'b0;
          end
          expect_word(mk(ST_OK, s, '0, 1'b1));
        end
      end
      CMD_OWNER: begin
        for (int i = 0; i < Depth; i++)
          if (occ_q[i] && owner_q[i] == cmd_mon.owner_tag) occ_q[i] = 1'b0;
        expect_word(mk(ST_OK, 0, '0, 1'b1));
      end
      CMD_CLEAR: begin
        for (int i = 0; i < Depth; i++) occ_q[i] = 1'b0;
        expect_word(mk(ST_OK, 0, '0, 1'b1));
      end
      CMD_QUERY: begin
        if (!slot_ok) begin
          expect_word(mk(ST_EMPTY, s, '0, 1'b1));
        end else begin
          n = 0;
          for (int i = 0; i < Depth && n < MaxOut; i++) begin
            if (i != s && occ_q[i] && shapes_touch(s, i)) begin
              expect_word(mk(ST_OK, i, owner_q[i], 1'b0));
              n++;
            end
          end
          if (n == 0) begin
            expect_word(mk(ST_NONE, s, '0, 1'b1));
          end else begin
            hit = result_q.pop_back();
            hit.last = 1'b1;
            expect_word(hit);
          end
        end
      end
      default: ;  // undefined commands leave no trace
    endcase
  endtask

  task automatic check_result();
    result_t want;
    if (result_q.size() == 0) begin
      $error("result word with nothing expected: status %0d slot %0d", res_mon.status,
             res_mon.hit_slot);
      fail_cnt_o++;
      return;
    end
    want = result_q.pop_front();
    if (res_mon.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, res_mon.status);
      fail_cnt_o++;
    end
    if (res_mon.hit_slot !== want.hit_slot) begin
      $error("hit_slot: expected %0d, got %0d", want.hit_slot, res_mon.hit_slot);
      fail_cnt_o++;
    end
    if (res_mon.hit_owner !== want.hit_owner) begin
      $error("hit_owner: expected %0d, got %0d", want.hit_owner, res_mon.hit_owner);
      fail_cnt_o++;
    end
    if (res_mon.last !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, res_mon.last);
      fail_cnt_o++;
    end
  endtask

  initial begin
    fail_cnt_o = 0;
    pending_o  = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) occ_q[i] = 1'b0;
      result_q.delete();
    end else begin
      if (cmd_mon.valid && cmd_mon.ready) predict_command();
      if (res_mon.valid && res_mon.ready) check_result();
    end
    pending_o = result_q.size();
  end

endmodule

FILE: tb/tb_collision_shape_table_query.sv
module tb_collision_shape_table_query;
  timeunit 1ns;
  timeprecision 1ps;
  import csq_pkg::*;

  // codes the block treats as undefined
  localparam logic [2:0] CMD_UNDEF_LO = 3'd6;
  localparam logic [2:0] CMD_UNDEF_HI = 3'd7;
  localparam logic [1:0] KIND_ODD     = 2'd3;

  // cycles with no word accepted on either channel before giving up
  localparam int StallLimit = 4000;
  // drain time after the last result, a full query walk and then some
  localparam int DrainCycles = 200;

  logic clk_i;
  logic rst_ni;
  int   fail_cnt;
  int   pending;
  int   snd_idle_pct;
  int   rcv_idle_pct;
  int   quiet_cycles;

  csq_cmd_if cmd_if ();
  csq_res_if res_if ();

  collision_shape_table_query dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .res_o  (res_if)
  );

  csq_scoreboard u_scoreboard (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_mon    (cmd_if),
    .res_mon    (res_if),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  // 12 ns period
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // result side back-pressure, changed only on the falling edge
  always @(negedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // watchdog: stops a hung run
  always @(posedge clk_i) begin
    if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("tb_collision_shape_table_query failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one command word; returns on the edge where it is taken
  task automatic send_word(logic [2:0] cmd, logic [3:0] slot, logic [1:0] kind,
                           logic [15:0] px, logic [15:0] py, logic [14:0] w,
                           logic [14:0] h, logic [14:0] r, logic [15:0] tag);
    @(negedge clk_i);
    // idle cycle by cycle at the set rate
    while ($urandom_range(99) < snd_idle_pct) begin
      cmd_if.valid = 1'b0;
      @(negedge clk_i);
    end
    cmd_if.cmd       = cmd;
    cmd_if.slot      = slot;
    cmd_if.kind      = kind;
    cmd_if.pos_x     = px;
    cmd_if.pos_y     = py;
    cmd_if.size_w    = w;
    cmd_if.size_h    = h;
    cmd_if.rad       = r;
    cmd_if.owner_tag = tag;
    cmd_if.valid     = 1'b1;
    do @(posedge clk_i); while (!cmd_if.ready);
  endtask

  // hold the sender off until every outstanding result is back
  task automatic drain();
    @(negedge clk_i);
    cmd_if.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // mostly near the origin so shapes meet, now and then anywhere
  function automatic logic [15:0] rnd_coord();
    if ($urandom_range(9) == 0) return 16'($urandom);
    return 16'($urandom_range(160) - 80);
  endfunction

  function automatic logic [14:0] rnd_size();
    if ($urandom_range(9) == 0) return 15'($urandom);
    return 15'($urandom_range(96));
  endfunction

  task automatic random_word();
    int          pick;
    logic [2:0]  cmd;
    logic [15:0] tag;
    pick = $urandom_range(99);
    if (pick < 30)      cmd = CMD_ADD;
    else if (pick < 38) cmd = CMD_MOVE;
    else if (pick < 46) cmd = CMD_REMOVE;
    else if (pick < 50) cmd = CMD_OWNER;
    else if (pick < 52) cmd = CMD_CLEAR;
    else if (pick < 98) cmd = CMD_QUERY;
    else                cmd = ($urandom_range(1)) ? CMD_UNDEF_LO : CMD_UNDEF_HI;
    // a few owners so remove-by-owner bites, sometimes any tag
    tag = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(3));
    send_word(cmd, 4'($urandom), ($urandom_range(19) == 0) ? KIND_ODD :
              2'($urandom_range(2)), rnd_coord(), rnd_coord(), rnd_size(), rnd_size(),
              rnd_size(), tag);
  endtask

  initial begin
    rst_ni           = 1'b0;
    quiet_cycles     = 0;
    snd_idle_pct     = 26;
    rcv_idle_pct     = 65;
    cmd_if.valid     = 1'b0;
    cmd_if.cmd       = CMD_CLEAR;
    cmd_if.slot      = '0;
    cmd_if.kind      = KIND_RECT;
    cmd_if.pos_x     = '0;
    cmd_if.pos_y     = '0;
    cmd_if.size_w    = '0;
    cmd_if.size_h    = '0;
    cmd_if.rad       = '0;
    cmd_if.owner_tag = '0;
    res_if.ready     = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, each command, the corner cases
    send_word(CMD_QUERY, 4'd0, KIND_RECT, '0, '0, '0, '0, '0, '0);          // query empty slot
    send_word(CMD_ADD, '0, KIND_RECT, 16'sh8000, 16'sh7fff, 15'h7fff, 15'h7fff, '0,
              16'hffff);
    send_word(CMD_ADD, '0, KIND_CIRC, 16'sh7fff, 16'sh8000, '0, '0, 15'h7fff, 16'h0);
    send_word(CMD_ADD, '0, KIND_POINT, 16'sd0, 16'sd0, '0, '0, '0, 16'h0001);
    send_word(CMD_ADD, '0, KIND_POINT, 16'sd0, 16'sd0, '0, '0, '0, 16'h0002);  // point on point
    send_word(CMD_ADD, '0, KIND_ODD, 16'sd0, 16'sd0, 15'd50, 15'd50, 15'd50, 16'h0003);
    send_word(CMD_ADD, '0, KIND_RECT, 16'sd16, 16'sd0, 15'd32, 15'd32, '0, 16'h0004);
    for (int s = 0; s < 7; s++)
      send_word(CMD_QUERY, 4'(s), KIND_RECT, '0, '0, '0, '0, '0, '0);
    send_word(CMD_MOVE, 4'd3, KIND_RECT, 16'sd32, 16'sd16, '0, '0, '0, '0);
    send_word(CMD_MOVE, 4'd15, KIND_RECT, '0, '0, '0, '0, '0, '0);           // move empty slot
    send_word(CMD_REMOVE, 4'd2, KIND_RECT, '0, '0, '0, '0, '0, '0);
    send_word(CMD_REMOVE, 4'd2, KIND_RECT, '0, '0, '0, '0, '0, '0);          // already gone
    send_word(CMD_OWNER, '0, KIND_RECT, '0, '0, '0, '0, '0, 16'h0000);       // owner zero
    send_word(CMD_UNDEF_LO, '0, KIND_RECT, '0, '0, '0, '0, '0, '0);
    send_word(CMD_UNDEF_HI, 4'hf, KIND_ODD, '1, '1, '1, '1, '1, '1);
    send_word(CMD_CLEAR, '0, KIND_RECT, '0, '0, '0, '0, '0, '0);
    drain();

    // random: three idling regimes, sender held off now and then
    for (int ph = 0; ph < 3; ph++) begin
      snd_idle_pct = (ph == 0) ? 26 : (ph == 1) ? 65 : 0;
      rcv_idle_pct = (ph == 0) ? 65 : (ph == 1) ? 26 : 0;
      for (int n = 0; n < 170; n++) begin
        random_word();
        if ($urandom_range(49) == 0) drain();
      end
      drain();
    end

    @(negedge clk_i);
    cmd_if.valid = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("tb_collision_shape_table_query passed");
    end else begin
      $display("tb_collision_shape_table_query failed");
    end
    $finish;
  end

endmodule
